[rtl/core/mipid_pkg.sv]
`default_nettype none

package mipid_pkg;

    // Default number of wheel loops
    localparam int MIPID_NUM_CHANNELS = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] REG_KP          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd3;

    localparam int GAIN_W      = 18;
    localparam int LIMIT_W     = 15;
    localparam int GAIN_FRAC_W = 12;

    localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RESET = 15'h7FFF;

    typedef struct packed {
        logic        [1:0]  channel;
        logic signed [15:0] setpoint;
        logic signed [15:0] measurement;
    } mipid_in_t;

    typedef struct packed {
        logic        [1:0]  out_channel;
        logic signed [15:0] drive;
        logic               clamped;
    } mipid_out_t;

endpackage

`default_nettype wire

[rtl/core/multichannel_incremental_pid.sv]
// Velocity-form PID for up to NUM_CHANNELS wheel loops sharing one set of gains. Each sample
// transaction names a channel and carries a setpoint and a measurement (signed Q8.8); the block
// forms e = setpoint - measurement, delta = (kp*(e-e1) + ki*e + kd*(e-2*e1+e2)) >>> 12 with
// Q6.12 gains, adds delta to the channel's held drive, clamps the sum to +/-drive_limit, stores
// it and returns it with a clamp flag. Samples for channels at or above NUM_CHANNELS leave all
// state alone and return drive 0, clamped 0. One sample transaction is taken every cycle
// unless result_ready back-pressure has filled every stage, including back-to-back samples on
// the same channel. That rate is set by the per-channel read-modify-write of the two state
// memories (error history, read at acceptance and written as the sample leaves stage 1; held
// drive, read as it enters the clamp stage and written as it leaves), each with write-to-read
// forwarding. Stages move independently, so bubbles close up and a sample is still taken while
// a result waits in the output register if a stage is empty. Per-channel state reads as zero
// after reset through per-entry valid bits; no clearing pass is needed. Configuration writes
// (kp, ki, kd, drive_limit) are always ready and must only be issued while no sample is in flight.
`default_nettype none

module multichannel_incremental_pid #(
    parameter int NUM_CHANNELS = mipid_pkg::MIPID_NUM_CHANNELS
) (
    input  wire                                    clk,
    input  wire                                    rst_n,

    input  wire                                    sample_valid,
    output logic                                   sample_ready,
    input  mipid_pkg::mipid_in_t                   sample,

    output logic                                   result_valid,
    input  wire                                    result_ready,
    output mipid_pkg::mipid_out_t                  result,

    input  wire                                    cfg_valid,
    output logic                                   cfg_ready,
    input  wire  [mipid_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [mipid_pkg::CFG_DATA_W-1:0]       cfg_data
);

    import mipid_pkg::*;

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CW = AW + 2;

    // One error-history entry per channel
    typedef struct packed {
        logic signed [16:0] last;
        logic signed [16:0] before_last;
    } err_entry_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [GAIN_W-1:0] kp_reg;
    logic signed [GAIN_W-1:0] ki_reg;
    logic signed [GAIN_W-1:0] kd_reg;
    logic [LIMIT_W-1:0]       limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg    <= '0;
            ki_reg    <= '0;
            kd_reg    <= '0;
            limit_reg <= DRIVE_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_KP:          kp_reg    <= cfg_data;
                REG_KI:          ki_reg    <= cfg_data;
                REG_KD:          kd_reg    <= cfg_data;
                REG_DRIVE_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: each stage advances when the next one is free
    // ------------------------------------------------------------------
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, out_v_reg;
    logic out_free, s4_rdy, s3_rdy, s2_rdy, s1_rdy;
    logic s1_adv, s3_adv, s4_adv, sample_fire;

    assign out_free     = !out_v_reg || result_ready;
    assign s4_rdy       = !s4_v_reg || out_free;
    assign s3_rdy       = !s3_v_reg || s4_rdy;
    assign s2_rdy       = !s2_v_reg || s3_rdy;
    assign s1_rdy       = !s1_v_reg || s2_rdy;
    assign s1_adv       = s1_v_reg && s2_rdy;
    assign s3_adv       = s3_v_reg && s4_rdy;
    assign s4_adv       = s4_v_reg && out_free;
    assign sample_ready = s1_rdy;
    assign sample_fire  = sample_valid && s1_rdy;
    assign result_valid = out_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_rdy)
            begin
                s1_v_reg <= sample_valid;
            end
            if (s2_rdy)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (s3_rdy)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (s4_rdy)
            begin
                s4_v_reg <= s3_v_reg;
            end
            if (out_free)
            begin
                out_v_reg <= s4_v_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sample decode
    // ------------------------------------------------------------------
    logic [CW-1:0]      sample_ch_wide;
    logic [AW-1:0]      sample_addr;
    logic               sample_in_range;
    logic signed [16:0] sample_err;

    assign sample_ch_wide  = CW'(sample.channel);
    assign sample_addr     = sample_ch_wide[AW-1:0];
    assign sample_in_range = sample_ch_wide < CW'(NUM_CHANNELS);
    assign sample_err      = $signed({sample.setpoint[15], sample.setpoint})
                           - $signed({sample.measurement[15], sample.measurement});

    // ------------------------------------------------------------------
    // Stage 1: error history read-modify-write, form the differences
    // ------------------------------------------------------------------
    err_entry_t               err_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]  err_vld_reg;

    logic [1:0]         s1_ch_reg;
    logic [AW-1:0]      s1_addr_reg;
    logic               s1_inr_reg;
    logic signed [16:0] s1_err_reg;
    err_entry_t         s1_err_rd_reg;
    logic               s1_err_vld_reg;
    logic               s1_err_hit_reg;
    err_entry_t         s1_err_fwd_reg;

    err_entry_t         s1_hist;
    logic               err_we;
    err_entry_t         err_wdata;
    logic signed [18:0] s1_e_x;
    logic signed [18:0] s1_e1_x;
    logic signed [18:0] s1_e2_x;
    logic signed [17:0] s1_dp;
    logic signed [18:0] s1_dd;

    // Take the entry the previous sample just wrote, else the memory, else reset zero
    assign s1_hist = s1_err_hit_reg ? s1_err_fwd_reg
                   : (s1_err_vld_reg ? s1_err_rd_reg : '0);

    assign err_we                = s1_adv && s1_inr_reg;
    assign err_wdata.last        = s1_err_reg;
    assign err_wdata.before_last = s1_hist.last;

    assign s1_e_x  = 19'(s1_err_reg);
    assign s1_e1_x = 19'(s1_hist.last);
    assign s1_e2_x = 19'(s1_hist.before_last);
    assign s1_dp   = 18'(s1_e_x - s1_e1_x);
    assign s1_dd   = s1_e_x - (s1_e1_x <<< 1) + s1_e2_x;

    always_ff @(posedge clk)
    begin
        if (err_we)
        begin
            err_mem[s1_addr_reg] <= err_wdata;
        end
        if (sample_fire)
        begin
            s1_err_rd_reg  <= err_mem[sample_addr];
            s1_err_vld_reg <= err_vld_reg[sample_addr];
            s1_err_hit_reg <= err_we && (s1_addr_reg == sample_addr);
            s1_err_fwd_reg <= err_wdata;
            s1_ch_reg      <= sample.channel;
            s1_addr_reg    <= sample_addr;
            s1_inr_reg     <= sample_in_range;
            s1_err_reg     <= sample_err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_vld_reg <= '0;
        end
        else if (err_we)
        begin
            err_vld_reg[s1_addr_reg] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: three gain multiplies in parallel
    // ------------------------------------------------------------------
    logic [1:0]         s2_ch_reg;
    logic [AW-1:0]      s2_addr_reg;
    logic               s2_inr_reg;
    logic signed [17:0] s2_dp_reg;
    logic signed [16:0] s2_e_reg;
    logic signed [18:0] s2_dd_reg;

    logic signed [35:0] s2_pp;
    logic signed [34:0] s2_pi;
    logic signed [36:0] s2_pd;

    assign s2_pp = 36'(kp_reg) * 36'(s2_dp_reg);
    assign s2_pi = 35'(ki_reg) * 35'(s2_e_reg);
    assign s2_pd = 37'(kd_reg) * 37'(s2_dd_reg);

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_ch_reg   <= s1_ch_reg;
            s2_addr_reg <= s1_addr_reg;
            s2_inr_reg  <= s1_inr_reg;
            s2_dp_reg   <= s1_dp;
            s2_e_reg    <= s1_err_reg;
            s2_dd_reg   <= s1_dd;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sum the products, drop the fraction (floor)
    // ------------------------------------------------------------------
    logic [1:0]         s3_ch_reg;
    logic [AW-1:0]      s3_addr_reg;
    logic               s3_inr_reg;
    logic signed [35:0] s3_pp_reg;
    logic signed [34:0] s3_pi_reg;
    logic signed [36:0] s3_pd_reg;

    logic signed [38:0] s3_acc;
    logic signed [26:0] s3_delta;

    assign s3_acc   = 39'(s3_pp_reg) + 39'(s3_pi_reg) + 39'(s3_pd_reg);
    assign s3_delta = s3_acc[38:GAIN_FRAC_W];

    always_ff @(posedge clk)
    begin
        if (s2_rdy && s2_v_reg)
        begin
            s3_ch_reg   <= s2_ch_reg;
            s3_addr_reg <= s2_addr_reg;
            s3_inr_reg  <= s2_inr_reg;
            s3_pp_reg   <= s2_pp;
            s3_pi_reg   <= s2_pi;
            s3_pd_reg   <= s2_pd;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: held drive read-modify-write, add delta and clamp
    // ------------------------------------------------------------------
    logic signed [15:0]       drv_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]  drv_vld_reg;

    logic [1:0]         s4_ch_reg;
    logic [AW-1:0]      s4_addr_reg;
    logic               s4_inr_reg;
    logic signed [26:0] s4_delta_reg;
    logic signed [15:0] s4_drv_rd_reg;
    logic               s4_drv_vld_reg;
    logic               s4_drv_hit_reg;
    logic signed [15:0] s4_drv_fwd_reg;

    logic signed [15:0] s4_held;
    logic signed [27:0] s4_sum;
    logic signed [27:0] lim_pos;
    logic signed [27:0] lim_neg;
    logic signed [27:0] s4_clip;
    logic               s4_lim;
    logic signed [15:0] s4_drive;
    logic               drv_we;

    assign s4_held = s4_drv_hit_reg ? s4_drv_fwd_reg
                   : (s4_drv_vld_reg ? s4_drv_rd_reg : '0);
    assign s4_sum  = 28'(s4_held) + 28'(s4_delta_reg);
    assign lim_pos = $signed(28'(limit_reg));
    assign lim_neg = -lim_pos;

    always_comb
    begin
        s4_clip = s4_sum;
        s4_lim  = 1'b0;
        if (s4_sum > lim_pos)
        begin
            s4_clip = lim_pos;
            s4_lim  = 1'b1;
        end
        else if (s4_sum < lim_neg)
        begin
            s4_clip = lim_neg;
            s4_lim  = 1'b1;
        end
    end

    assign s4_drive = s4_clip[15:0];
    assign drv_we   = s4_adv && s4_inr_reg;

    always_ff @(posedge clk)
    begin
        if (drv_we)
        begin
            drv_mem[s4_addr_reg] <= s4_drive;
        end
        if (s3_adv)
        begin
            s4_drv_rd_reg  <= drv_mem[s3_addr_reg];
            s4_drv_vld_reg <= drv_vld_reg[s3_addr_reg];
            s4_drv_hit_reg <= drv_we && (s4_addr_reg == s3_addr_reg);
            s4_drv_fwd_reg <= s4_drive;
            s4_ch_reg      <= s3_ch_reg;
            s4_addr_reg    <= s3_addr_reg;
            s4_inr_reg     <= s3_inr_reg;
            s4_delta_reg   <= s3_delta;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_vld_reg <= '0;
        end
        else if (drv_we)
        begin
            drv_vld_reg[s4_addr_reg] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Output register: hold the result until the transaction completes
    // ------------------------------------------------------------------
    mipid_out_t result_reg;

    assign result = result_reg;

    always_ff @(posedge clk)
    begin
        if (s4_adv)
        begin
            result_reg.out_channel <= s4_ch_reg;
            result_reg.drive       <= s4_inr_reg ? s4_drive : '0;
            result_reg.clamped     <= s4_inr_reg && s4_lim;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic [CW-1:0] result_ch_wide;

    assign result_ch_wide = CW'(result.out_channel);

    a_drive_within_limit : assert property (@(posedge clk) disable iff (!rst_n)
        drv_we |-> (s4_clip <= lim_pos && s4_clip >= lim_neg))
        else $error("stored drive outside the clamp range");

    a_clamp_hits_limit : assert property (@(posedge clk) disable iff (!rst_n)
        (s4_v_reg && s4_lim) |-> (s4_clip == lim_pos || s4_clip == lim_neg))
        else $error("clamp flag set but drive not at the limit");

    a_unused_channel_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ch_wide >= CW'(NUM_CHANNELS))
            |-> (result.drive == '0 && !result.clamped))
        else $error("unused channel produced a nonzero result");

    a_sample_enters_pipe : assert property (@(posedge clk) disable iff (!rst_n)
        sample_fire |=> s1_v_reg)
        else $error("accepted sample lost before stage one");

endmodule

`default_nettype wire

[tb/tb_multichannel_incremental_pid.sv]
`timescale 1ns / 100ps

module tb_multichannel_incremental_pid;
    import mipid_pkg::*;

    localparam int NUM_CH = MIPID_NUM_CHANNELS;

    // Percentage of cycles in which a side idles while random idling is on
    localparam int IDLE_PCT = 25;

    // Length of the one long receiver hold-off, in cycles
    localparam int RX_HOLD_CYCLES = 80;

    // Settle time after a drain, before touching registers
    localparam int SETTLE_CYCLES = 8;

    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 50;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic       sample_valid = 1'b0;
    logic       sample_ready;
    mipid_in_t  sample       = '0;

    logic       result_valid;
    logic       result_ready = 1'b0;
    mipid_out_t result;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    multichannel_incremental_pid #(
        .NUM_CHANNELS(NUM_CH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Controller mirror: shared gains and clamp magnitude, plus the
    // per-channel error history and held drive.
    // ------------------------------------------------------------------
    longint             gain_p = 0;
    longint             gain_i = 0;
    longint             gain_d = 0;
    logic [LIMIT_W-1:0] limit_mag = DRIVE_LIMIT_RESET;

    longint err_hist1   [NUM_CH] = '{default: 0};
    longint err_hist2   [NUM_CH] = '{default: 0};
    longint drive_state [NUM_CH] = '{default: 0};

    // Pending sample transactions and the drive results they must produce
    mipid_in_t  sample_q[$];
    mipid_out_t expected_drive_q[$];

    // Shared idling controls, set by the sequencer at a falling edge
    bit no_idle         = 1'b1;
    int rx_hold_request = 0;

    int samples_sent    = 0;
    int results_checked = 0;
    int clamp_hits      = 0;
    int settings_done   = 0;
    int mismatch_count  = 0;

    // Work out the drive for one sample and advance the channel's state.
    // Velocity form: the new drive is the held drive plus the floor-shifted
    // sum of the three gain products, clamped symmetrically.
    function automatic mipid_out_t predict_drive(mipid_in_t s);
        mipid_out_t r;
        longint     err;
        longint     e1;
        longint     e2;
        longint     acc;
        longint     total;
        longint     lim;
        r.out_channel = s.channel;
        r.drive       = '0;
        r.clamped     = 1'b0;
        // A channel beyond the configured count returns zero and leaves state alone
        if (s.channel >= NUM_CH)
            return r;
        err = longint'($signed(s.setpoint)) - longint'($signed(s.measurement));
        e1  = err_hist1[s.channel];
        e2  = err_hist2[s.channel];
        acc = gain_p * (err - e1) + gain_i * err + gain_d * (err - 2 * e1 + e2);
        // Arithmetic shift of a signed longint rounds toward minus infinity
        total = drive_state[s.channel] + (acc >>> GAIN_FRAC_W);
        lim   = longint'(limit_mag);
        if (total > lim)
        begin
            total     = lim;
            r.clamped = 1'b1;
        end
        else if (total < -lim)
        begin
            total     = -lim;
            r.clamped = 1'b1;
        end
        drive_state[s.channel] = total;
        err_hist2[s.channel]   = e1;
        err_hist1[s.channel]   = err;
        r.drive = total[15:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sample driver: record a prediction on every accepted transaction,
    // then load the next one when the slot is free and this cycle is not
    // an idle cycle. Valid holds until the transaction is taken.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample       <= '0;
        end
        else
        begin
            if (sample_valid && sample_ready)
            begin
                expected_drive_q.push_back(predict_drive(sample));
                samples_sent++;
            end
            if (!sample_valid || sample_ready)
            begin
                if (sample_q.size() != 0 &&
                    (no_idle || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    sample       <= sample_q.pop_front();
                    sample_valid <= 1'b1;
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare every accepted result against the oldest
    // expectation, and throttle result_ready. A new hold-off request
    // drops ready until the rx_hold_left countdown here runs out.
    // ------------------------------------------------------------------
    int rx_hold_served = 0;
    int rx_hold_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        mipid_out_t want;
        if (!rst_n)
        begin
            result_ready   <= 1'b0;
            rx_hold_left   <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_drive_q.size() == 0)
                begin
                    $display("%0t: unexpected result ch=%0d drive=%0d clamped=%0b",
                             $time, result.out_channel, $signed(result.drive),
                             result.clamped);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_drive_q.pop_front();
                    results_checked++;
                    if (want.clamped)
                        clamp_hits++;
                    if (result.out_channel !== want.out_channel)
                    begin
                        $display("%0t: out_channel mismatch: expected %0d, actual %0d",
                                 $time, want.out_channel, result.out_channel);
                        mismatch_count++;
                    end
                    if (result.drive !== want.drive)
                    begin
                        $display("%0t: drive mismatch (ch %0d): expected %0d, actual %0d",
                                 $time, want.out_channel, $signed(want.drive),
                                 $signed(result.drive));
                        mismatch_count++;
                    end
                    if (result.clamped !== want.clamped)
                    begin
                        $display("%0t: clamped mismatch (ch %0d): expected %0b, actual %0b",
                                 $time, want.out_channel, want.clamped, result.clamped);
                        mismatch_count++;
                    end
                end
            end

            if (rx_hold_served != rx_hold_request)
            begin
                rx_hold_served <= rx_hold_request;
                rx_hold_left   <= RX_HOLD_CYCLES;
                result_ready   <= 1'b0;
            end
            else if (rx_hold_left != 0)
            begin
                rx_hold_left <= rx_hold_left - 1;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer helpers
    // ------------------------------------------------------------------

    // Issue one register write from a rising-edge step and hold until taken.
    // Leaves cfg_valid high so a following write continues back to back.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_KP:          gain_p    = longint'($signed(data));
            REG_KI:          gain_i    = longint'($signed(data));
            REG_KD:          gain_d    = longint'($signed(data));
            REG_DRIVE_LIMIT: limit_mag = data[LIMIT_W-1:0];
            default:         ;  // unmapped index: the block drops the write
        endcase
    endtask

    // Load a full setting, with one write to an unmapped index mixed in
    task automatic apply_setting(input logic [CFG_DATA_W-1:0] p,
                                 input logic [CFG_DATA_W-1:0] i,
                                 input logic [CFG_DATA_W-1:0] d,
                                 input logic [CFG_DATA_W-1:0] lim);
        @(posedge clk);
        write_reg(REG_KP, p);
        write_reg(CFG_IDX_W'($urandom_range(int'(REG_DRIVE_LIMIT) + 1,
                                            (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom));
        write_reg(REG_KI, i);
        write_reg(REG_KD, d);
        write_reg(REG_DRIVE_LIMIT, lim);
        cfg_valid <= 1'b0;
        settings_done++;
    endtask

    // Hold the sender until every queued sample is taken and every
    // expected result has come back, then let the pipeline settle.
    // Check at the falling edge, where the driver's updates have landed.
    task automatic wait_drained();
        while (sample_q.size() != 0 || sample_valid || expected_drive_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic mipid_in_t make_sample(input int ch, input int sp, input int meas);
        mipid_in_t s;
        s.channel     = ch[1:0];
        s.setpoint    = sp[15:0];
        s.measurement = meas[15:0];
        return s;
    endfunction

    // Mostly tracking-style samples with small errors, the rest anywhere
    function automatic mipid_in_t rand_sample();
        mipid_in_t s;
        s.channel = 2'($urandom_range(0, NUM_CH - 1));
        if ($urandom_range(0, 9) < 4)
        begin
            s.setpoint    = 16'($urandom);
            s.measurement = 16'($urandom);
        end
        else
        begin
            s.setpoint    = 16'($urandom_range(0, 4000) - 2000);
            s.measurement = 16'(s.setpoint + ($urandom_range(0, 600) - 300));
        end
        return s;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_gain();
        case ($urandom_range(0, 3))
            0:       return CFG_DATA_W'($urandom);
            1:       return CFG_DATA_W'($urandom_range(0, 8191) - 4096);
            2:       return $urandom_range(0, 1) ? 18'h1FFFF : 18'h20000;
            default: return CFG_DATA_W'($urandom_range(0, 1023) - 512);
        endcase
    endfunction

    // Full-width data on the limit write so the ignored upper bits toggle too
    function automatic logic [CFG_DATA_W-1:0] rand_limit();
        case ($urandom_range(0, 4))
            0:       return CFG_DATA_W'($urandom);
            1:       return CFG_DATA_W'($urandom_range(0, 2000));
            2:       return {3'($urandom), 15'h7FFF};
            3:       return {3'($urandom), 15'h0000};
            default: return CFG_DATA_W'($urandom_range(256, 8192));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial
    begin
        int phase;
        int n;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Reset gains are zero: any error leaves the drive at zero
        @(negedge clk);
        no_idle = 1'b1;
        sample_q.push_back(make_sample(0, 32767, -32768));
        sample_q.push_back(make_sample(3, -32768, 32767));
        wait_drained();

        // Unity kp, half ki, quarter kd: field extremes, back-to-back
        // samples on one channel, and both signs of the widest error
        apply_setting(18'd4096, 18'd2048, 18'd1024, 18'h07FFF);
        @(negedge clk);
        sample_q.push_back(make_sample(0, 32767, -32768));
        sample_q.push_back(make_sample(0, -32768, 32767));
        sample_q.push_back(make_sample(1, 0, 0));
        sample_q.push_back(make_sample(2, 256, -256));
        sample_q.push_back(make_sample(2, 256, -256));
        sample_q.push_back(make_sample(3, -32768, -32768));
        sample_q.push_back(make_sample(3, 32767, 32767));
        sample_q.push_back(make_sample(1, -1, 0));
        wait_drained();

        // Gain extremes, and a limit write whose bits above the field are set
        apply_setting(18'h1FFFF, 18'h20000, 18'h1FFFF, 18'h38123);
        @(negedge clk);
        sample_q.push_back(make_sample(0, 32767, -32768));
        sample_q.push_back(make_sample(1, 100, 50));
        sample_q.push_back(make_sample(2, -32768, 32767));
        sample_q.push_back(make_sample(3, 0, 0));
        sample_q.push_back(make_sample(0, 0, 0));
        wait_drained();

        // Zero limit pins the drive at zero; a channel whose error settles
        // at zero with zero history gives an unclamped zero
        apply_setting(18'h20000, 18'h1FFFF, 18'h20000, 18'h00000);
        @(negedge clk);
        sample_q.push_back(make_sample(0, 1000, -1000));
        sample_q.push_back(make_sample(1, 5, 5));
        sample_q.push_back(make_sample(1, 5, 5));
        sample_q.push_back(make_sample(1, 5, 5));
        sample_q.push_back(make_sample(1, 5, 5));
        sample_q.push_back(make_sample(2, -32768, 32767));
        wait_drained();

        // Random phases, each under a fresh random setting
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            apply_setting(rand_gain(), rand_gain(), rand_gain(), rand_limit());
            @(negedge clk);
            // One phase runs with no idling on either side
            no_idle = (phase == 2);
            // One phase stalls the receiver long enough to back up the input
            if (phase == 5)
                rx_hold_request++;
            for (n = 0; n < PHASE_ITEMS; n++)
                sample_q.push_back(rand_sample());
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d samples over %0d gain/limit settings on %0d channels;",
                 samples_sent, settings_done, NUM_CH);
        $display("%0d drive results checked, %0d of them at the clamp.",
                 results_checked, clamp_hits);
        if (mismatch_count == 0 && expected_drive_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #400000;
        $display("Timeout: %0d results still outstanding", expected_drive_q.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
